// ===== design/scpd_pkg.sv =====
`default_nettype none
package scpd_pkg;

   localparam int NOW_W      = 32;
   localparam int VAL_W      = 16;
   localparam int CHECK_W    = 26;
   localparam int DIVISOR_W  = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 26;

   typedef logic [VAL_W-1:0]      value_type;
   typedef logic [CHECK_W-1:0]    check_type;
   typedef logic [DIVISOR_W-1:0]  divisor_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   // percentage deltas are in units of 0.01 percent
   localparam value_type PCT_SCALE = 16'd10000;

   localparam csr_idx_type REG_PUBLISH_PERIOD = 3'd0;
   localparam csr_idx_type REG_FAST_DIVISOR   = 3'd1;
   localparam csr_idx_type REG_MIN_INTERVAL   = 3'd2;
   localparam csr_idx_type REG_DELTA_UP       = 3'd3;
   localparam csr_idx_type REG_DELTA_DOWN     = 3'd4;
   localparam csr_idx_type REG_PERCENT_MODE   = 3'd5;
   localparam csr_idx_type REG_FAST_LOW       = 3'd6;
   localparam csr_idx_type REG_FAST_HIGH      = 3'd7;

   localparam check_type   RST_PUBLISH_PERIOD = 26'd320000;
   localparam divisor_type RST_FAST_DIVISOR   = 16'd32;
   localparam check_type   RST_MIN_INTERVAL   = 26'd1024;
   localparam value_type   RST_DELTA_UP       = 16'd1;
   localparam value_type   RST_DELTA_DOWN     = 16'd0;
   localparam value_type   RST_FAST_LOW       = 16'd1;
   localparam value_type   RST_FAST_HIGH      = 16'd0;

   typedef struct packed {
      logic        start;
      check_type   dividend;
      divisor_type divisor;
   } div_cmd_type;

   typedef struct packed {
      logic      done;
      check_type quotient;
   } div_stat_type;

endpackage
`default_nettype wire

// ===== design/scpd_req_if.sv =====
`default_nettype none
interface scpd_req_if;
   logic                         valid;
   logic                         ready;
   logic [scpd_pkg::NOW_W-1:0]   now_ms;
   logic [scpd_pkg::VAL_W-1:0]   reading;

   modport source (output valid, output now_ms, output reading, input ready);
   modport sink (input valid, input now_ms, input reading, output ready);
endinterface
`default_nettype wire

// ===== design/scpd_rsp_if.sv =====
`default_nettype none
interface scpd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         publish_now;
   logic [scpd_pkg::VAL_W-1:0]   reported_value;
   logic [scpd_pkg::CHECK_W-1:0] next_check_ms;

   modport source (output valid, output publish_now, output reported_value,
                   output next_check_ms, input ready);
   modport sink (input valid, input publish_now, input reported_value,
                 input next_check_ms, output ready);
endinterface
`default_nettype wire

// ===== design/scpd_csr_if.sv =====
`default_nettype none
interface scpd_csr_if;
   logic                            valid;
   logic                            ready;
   logic [scpd_pkg::CSR_IDX_W-1:0]  index;
   logic [scpd_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== design/scpd_div.sv =====
`default_nettype none
module scpd_div (
   input  wire                    clock,
   input  wire                    reset,
   input  scpd_pkg::div_cmd_type  cmd,
   output scpd_pkg::div_stat_type stat
);

   localparam int STEPS = scpd_pkg::CHECK_W;
   localparam int CNT_W = $clog2(STEPS);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   scpd_pkg::check_type       quo_ff, quo_in;
   scpd_pkg::divisor_type     rem_ff, rem_in;
   scpd_pkg::divisor_type     divisor_ff, divisor_in;
   logic [scpd_pkg::DIVISOR_W:0] shifted;
   scpd_pkg::divisor_type     diff;
   logic                      ge;

   // one restoring radix-2 step per cycle
   // when ge the remainder is below the divisor, so the low bits of the difference suffice
   assign shifted = {rem_ff, quo_ff[STEPS-1]};
   assign ge      = shifted >= {1'b0, divisor_ff};
   assign diff    = shifted[scpd_pkg::DIVISOR_W-1:0] - divisor_ff;

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (cmd.start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         quo_in     = cmd.dividend;
         rem_in     = '0;
         divisor_in = cmd.divisor;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[STEPS-2:0], ge};
         rem_in   = ge ? diff : shifted[scpd_pkg::DIVISOR_W-1:0];
         count_in = count_ff + 1'b1;
         if (count_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign stat.done     = done_ff;
   assign stat.quotient = quo_ff;

endmodule
`default_nettype wire

// ===== design/sensor_cadence_publish_decider.sv =====
// Sensor cadence publish decider.
// req_ch carries one evaluation request: a wrapping millisecond timestamp and
// a sensor reading. rsp_ch returns one result per request: whether the reading
// is published, the last published value and the time to the next check.
// csr_ch writes the cadence registers by index; it is always ready and is to
// be written only while no request is in flight, which the block does not enforce.
// A request passes from acceptance through the 26-step serial divider that
// forms the fast cadence period, two products on a shared multiplier and the
// decision cycle to a valid result; the block takes no new request until the
// previous one has left the decision cycle.
// The result sits in an output register: a stalled receiver does not keep the
// block from accepting and working on the next request, but that request's
// result waits in the decision cycle until the register is free.
// Reset loads the register defaults, clears the last published value and time
// and empties the output register.
`default_nettype none
module sensor_cadence_publish_decider #(
   parameter int VALUE_BITS = 16,
   parameter int TIME_BITS  = 32
) (
   input  wire         clock,
   input  wire         reset,
   scpd_req_if.sink    req_ch,
   scpd_rsp_if.source  rsp_ch,
   scpd_csr_if.sink    csr_ch
);

   localparam int VB = (VALUE_BITS < scpd_pkg::VAL_W) ? VALUE_BITS : scpd_pkg::VAL_W;
   localparam scpd_pkg::value_type VAL_MASK = scpd_pkg::value_type'((64'd1 << VB) - 64'd1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DIV    = 3'd1;
   localparam logic [2:0] ST_MUL_A  = 3'd2;
   localparam logic [2:0] ST_MUL_B  = 3'd3;
   localparam logic [2:0] ST_DECIDE = 3'd4;

   logic [2:0] state_ff, state_in;

   // cadence registers
   scpd_pkg::check_type   period_ff;
   scpd_pkg::divisor_type fast_div_ff;
   scpd_pkg::check_type   min_ff;
   scpd_pkg::value_type   delta_up_ff;
   scpd_pkg::value_type   delta_down_ff;
   logic                  pct_ff;
   scpd_pkg::value_type   fast_low_ff;
   scpd_pkg::value_type   fast_high_ff;

   // published state
   scpd_pkg::value_type   last_value_ff, last_value_in;
   logic [TIME_BITS-1:0]  last_time_ff, last_time_in;

   // request in progress
   logic [TIME_BITS-1:0]  now_ff, now_in;
   scpd_pkg::value_type   cur_ff, cur_in;
   scpd_pkg::check_type   fp_ff, fp_in;
   logic [32:0]           prod_a_ff, prod_a_in;
   logic [32:0]           prod_b_ff, prod_b_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  publish_ff, publish_in;
   scpd_pkg::value_type   value_ff, value_in;
   scpd_pkg::check_type   check_ff, check_in;

   scpd_pkg::div_cmd_type  div_cmd;
   scpd_pkg::div_stat_type div_stat;

   logic                  req_take;
   logic                  load;
   logic                  up_case;
   scpd_pkg::value_type   diff;
   scpd_pkg::value_type   dsel;
   logic [16:0]           mul_a;
   scpd_pkg::value_type   mul_b;
   logic [32:0]           mul_out;
   logic [TIME_BITS-1:0]  elapsed;
   logic [31:0]           elapsed_w;
   logic                  dnz;
   logic                  fast_on;
   logic                  blocked;
   logic                  hit_period;
   logic                  hit_native;
   logic                  hit_pct;
   logic                  hit_delta;
   logic                  in_range;
   logic                  hit_fast;
   logic                  hit_change;
   logic                  pub;
   scpd_pkg::check_type   t_base;
   scpd_pkg::check_type   t_next;

   assign req_take      = req_ch.valid && req_ch.ready;
   assign req_ch.ready  = state_ff == ST_IDLE;
   assign csr_ch.ready  = 1'b1;

   assign div_cmd.start    = req_take;
   assign div_cmd.dividend = period_ff;
   assign div_cmd.divisor  = fast_div_ff;

   scpd_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .stat  (div_stat)
   );

   // percentage check without a divider: floor(d*10000/c) > k  <=>  d*10000 >= (k+1)*c
   assign up_case = cur_ff > last_value_ff;
   assign diff    = up_case ? cur_ff - last_value_ff : last_value_ff - cur_ff;
   assign dsel    = up_case ? delta_up_ff : delta_down_ff;
   assign mul_a   = (state_ff == ST_MUL_A) ? {1'b0, diff} : {1'b0, dsel} + 17'd1;
   assign mul_b   = (state_ff == ST_MUL_A) ? scpd_pkg::PCT_SCALE : cur_ff;
   assign mul_out = 33'(mul_a) * 33'(mul_b);

   assign elapsed   = now_ff - last_time_ff;
   assign elapsed_w = 32'(elapsed);
   assign dnz       = (delta_up_ff != '0) || (delta_down_ff != '0);
   assign fast_on   = fast_div_ff > scpd_pkg::divisor_type'(1);
   assign blocked   = (min_ff != '0) && (elapsed_w < 32'(min_ff));

   assign hit_period = (period_ff != '0) && (elapsed_w >= 32'(period_ff));

   assign hit_native =
      ((delta_up_ff != '0) &&
       (17'(cur_ff) >= 17'(last_value_ff) + 17'(delta_up_ff))) ||
      ((delta_down_ff != '0) && (last_value_ff >= delta_down_ff) &&
       (cur_ff <= last_value_ff - delta_down_ff));

   assign hit_pct   = (cur_ff == '0) ? (last_value_ff != '0) : (prod_a_ff >= prod_b_ff);
   assign hit_delta = dnz && (pct_ff ? hit_pct : hit_native);

   always_comb begin
      if (fast_high_ff > fast_low_ff) begin
         in_range = (cur_ff > fast_low_ff) && (cur_ff <= fast_high_ff);
      end else if (fast_high_ff < fast_low_ff) begin
         in_range = (cur_ff >= fast_low_ff) || (cur_ff < fast_high_ff);
      end else begin
         in_range = 1'b0;
      end
   end

   assign hit_fast   = fast_on && (fp_ff != '0) && (elapsed_w >= 32'(fp_ff)) && in_range;
   assign hit_change = !dnz && (cur_ff != last_value_ff);
   assign pub        = !blocked && (hit_period || hit_delta || hit_fast || hit_change);

   assign t_base = fast_on ? fp_ff : period_ff;
   assign t_next = ((min_ff != '0) && (min_ff > t_base) && dnz) ? min_ff : t_base;

   assign load = (state_ff == ST_DECIDE) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      state_in      = state_ff;
      now_in        = now_ff;
      cur_in        = cur_ff;
      fp_in         = fp_ff;
      prod_a_in     = prod_a_ff;
      prod_b_in     = prod_b_ff;
      last_value_in = last_value_ff;
      last_time_in  = last_time_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      publish_in    = publish_ff;
      value_in      = value_ff;
      check_in      = check_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               now_in   = req_ch.now_ms[TIME_BITS-1:0];
               cur_in   = req_ch.reading & VAL_MASK;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               fp_in    = div_stat.quotient;
               state_in = ST_MUL_A;
            end
         end
         ST_MUL_A: begin
            prod_a_in = mul_out;
            state_in  = ST_MUL_B;
         end
         ST_MUL_B: begin
            prod_b_in = mul_out;
            state_in  = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (load) begin
               if (pub) begin
                  last_value_in = cur_ff;
                  last_time_in  = now_ff;
               end
               rsp_valid_in = 1'b1;
               publish_in   = pub;
               value_in     = pub ? cur_ff : last_value_ff;
               check_in     = (period_ff == '0) ? '0 : t_next;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         last_value_ff <= '0;
         last_time_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         last_value_ff <= last_value_in;
         last_time_ff  <= last_time_in;
      end
      now_ff     <= now_in;
      cur_ff     <= cur_in;
      fp_ff      <= fp_in;
      prod_a_ff  <= prod_a_in;
      prod_b_ff  <= prod_b_in;
      publish_ff <= publish_in;
      value_ff   <= value_in;
      check_ff   <= check_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff     <= scpd_pkg::RST_PUBLISH_PERIOD;
         fast_div_ff   <= scpd_pkg::RST_FAST_DIVISOR;
         min_ff        <= scpd_pkg::RST_MIN_INTERVAL;
         delta_up_ff   <= scpd_pkg::RST_DELTA_UP;
         delta_down_ff <= scpd_pkg::RST_DELTA_DOWN;
         pct_ff        <= 1'b0;
         fast_low_ff   <= scpd_pkg::RST_FAST_LOW;
         fast_high_ff  <= scpd_pkg::RST_FAST_HIGH;
      end else if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.index)
            scpd_pkg::REG_PUBLISH_PERIOD: period_ff     <= csr_ch.data;
            scpd_pkg::REG_FAST_DIVISOR:   fast_div_ff   <= csr_ch.data[15:0];
            scpd_pkg::REG_MIN_INTERVAL:   min_ff        <= csr_ch.data;
            scpd_pkg::REG_DELTA_UP:       delta_up_ff   <= csr_ch.data[15:0];
            scpd_pkg::REG_DELTA_DOWN:     delta_down_ff <= csr_ch.data[15:0];
            scpd_pkg::REG_PERCENT_MODE:   pct_ff        <= csr_ch.data[0];
            scpd_pkg::REG_FAST_LOW:       fast_low_ff   <= csr_ch.data[15:0];
            scpd_pkg::REG_FAST_HIGH:      fast_high_ff  <= csr_ch.data[15:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.publish_now    = publish_ff;
   assign rsp_ch.reported_value = value_ff;
   assign rsp_ch.next_check_ms  = check_ff;

`ifndef SYNTH
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide step");

   a_rsp_value_tracks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> value_ff == last_value_ff)
      else $error("reported value differs from last published value");

   a_publish_time: assert property (@(posedge clock) disable iff (reset)
      load && pub |=> last_time_ff == $past(now_ff))
      else $error("publish did not record its timestamp");

   a_blocked_no_publish: assert property (@(posedge clock) disable iff (reset)
      load && blocked |=> rsp_valid_ff && !publish_ff)
      else $error("published inside the minimum interval");
`endif

endmodule
`default_nettype wire
